/* design/slcd_pkg.sv */
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

  // Default payload store depth
  localparam int unsigned MaxPayloadDefault = 32;

  // Register reset values
  localparam logic [7:0] SyncReset  = 8'h11;
  localparam logic [6:0] LimitReset = 7'd32;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC  = 1'b0,
    CFG_LIMIT = 1'b1
  } cfg_idx_t;

  // Parser phases; release streams the stored payload out
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_RELEASE
  } phase_t;

  // Store access strobes from the parser
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

/* design/slcd_channels.sv */
// ----------------------------------------------------------------------------
// slcd_channels
// Valid/ready channels for received bytes and verified payload results.
// ----------------------------------------------------------------------------
interface slcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slcd_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [6:0] frame_length;
  logic       last_of_frame;
  logic       empty_frame;

  modport source (output valid, output payload_byte, output frame_length,
                  output last_of_frame, output empty_frame, input ready);
  modport sink   (input valid, input payload_byte, input frame_length,
                  input last_of_frame, input empty_frame, output ready);
endinterface

/* design/slcd_store.sv */
// ----------------------------------------------------------------------------
// slcd_store
// Payload store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slcd_store #(
  parameter int unsigned MAX_PAYLOAD = slcd_pkg::MaxPayloadDefault,
  parameter int unsigned AW          = 5
) (
  input  logic                   clk,
  input  slcd_pkg::store_ctl_t   st_ctl,
  input  logic [AW-1:0]          wr_addr,
  input  logic [7:0]             wr_data,
  input  logic [AW-1:0]          rd_addr,
  output logic [7:0]             rd_data
);
  import slcd_pkg::*;

  logic [7:0] mem [MAX_PAYLOAD];

  // Write payload bytes as they arrive
  always_ff @(posedge clk) begin
    if (st_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry per cycle during release while the output is not stalled
  always_ff @(posedge clk) begin
    if (st_ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/slcd_parser.sv */
// ----------------------------------------------------------------------------
// slcd_parser
// Frame parser: sync hunt, length check, checksum, release sequencing and
// the output control register.
// ----------------------------------------------------------------------------
module slcd_parser #(
  parameter int unsigned MAX_PAYLOAD = slcd_pkg::MaxPayloadDefault,
  parameter int unsigned AW          = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [slcd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [slcd_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          rx_valid,
  input  logic [7:0]                    rx_byte,
  output logic                          rx_ready,
  input  logic                          tx_ready,
  output logic                          tx_valid,
  output logic [6:0]                    tx_len,
  output logic                          tx_last,
  output logic                          tx_empty,
  output slcd_pkg::store_ctl_t          st_ctl,
  output logic [AW-1:0]                 wr_addr,
  output logic [7:0]                    wr_data,
  output logic [AW-1:0]                 rd_addr
);
  import slcd_pkg::*;

  localparam logic [6:0] MaxLen = 7'(MAX_PAYLOAD);

  logic [7:0] sync_value;
  logic [6:0] length_limit;
  phase_t     phase, phase_next;
  logic [6:0] exp_len;
  logic [6:0] cnt;
  logic [7:0] running_sum;

  logic [6:0] eff_limit;
  logic [6:0] cnt_inc;
  logic       rx_fire;
  logic       sum_ok;
  logic       len_bad;
  logic       rel_last;
  logic       empty_load;

  assign eff_limit = (length_limit < MaxLen) ? length_limit : MaxLen;
  assign cnt_inc   = cnt + 7'd1;
  assign rx_fire   = rx_valid && rx_ready;
  assign sum_ok    = (rx_byte == running_sum);
  assign len_bad   = (rx_byte > {1'b0, eff_limit});
  assign rel_last  = (cnt == exp_len - 7'd1);
  assign wr_addr   = cnt[AW-1:0];
  assign rd_addr   = cnt[AW-1:0];
  assign wr_data   = rx_byte;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value   <= SyncReset;
      length_limit <= LimitReset;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SYNC:  sync_value   <= cfg_data;
        CFG_LIMIT: length_limit <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT: begin
        if (rx_fire && rx_byte == sync_value) phase_next = PH_LEN;
      end
      PH_LEN: begin
        if (rx_fire) begin
          if (len_bad)              phase_next = PH_HUNT;
          else if (rx_byte == 8'd0) phase_next = PH_SUM;
          else                      phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        if (rx_fire && cnt_inc >= exp_len) phase_next = PH_SUM;
      end
      PH_SUM: begin
        if (rx_fire) begin
          if (sum_ok && exp_len != 7'd0) phase_next = PH_RELEASE;
          else                           phase_next = PH_HUNT;
        end
      end
      PH_RELEASE: begin
        if (st_ctl.rd_en && rel_last) phase_next = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // Phase outputs: handshake and store strobes
  always_comb begin
    rx_ready     = 1'b0;
    st_ctl.wr_en = 1'b0;
    st_ctl.rd_en = 1'b0;
    empty_load   = 1'b0;
    case (phase)
      PH_HUNT, PH_LEN: begin
        rx_ready = 1'b1;
      end
      PH_DATA: begin
        rx_ready     = 1'b1;
        st_ctl.wr_en = rx_valid && (cnt < MaxLen);
      end
      PH_SUM: begin
        // hold off until the output slot can take an empty-frame result
        rx_ready   = !tx_valid;
        empty_load = rx_valid && !tx_valid && sum_ok && (exp_len == 7'd0);
      end
      PH_RELEASE: begin
        st_ctl.rd_en = !tx_valid || tx_ready;
      end
      default: ;
    endcase
  end

  // Phase, counters and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      exp_len     <= 7'd0;
      cnt         <= 7'd0;
      running_sum <= 8'd0;
    end else begin
      phase <= phase_next;
      case (phase)
        PH_HUNT: begin
          if (rx_fire && rx_byte == sync_value) running_sum <= rx_byte;
        end
        PH_LEN: begin
          if (rx_fire && !len_bad) begin
            exp_len     <= rx_byte[6:0];
            cnt         <= 7'd0;
            running_sum <= running_sum + rx_byte;
          end
        end
        PH_DATA: begin
          if (rx_fire) begin
            cnt         <= cnt_inc;
            running_sum <= running_sum + rx_byte;
          end
        end
        PH_SUM: begin
          if (rx_fire) cnt <= 7'd0;
        end
        PH_RELEASE: begin
          if (st_ctl.rd_en) cnt <= cnt_inc;
        end
        default: ;
      endcase
    end
  end

  // Output register; payload data sits in the store read register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (st_ctl.rd_en || empty_load) begin
      tx_valid <= 1'b1;
    end else if (tx_ready) begin
      tx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_ctl.rd_en) begin
      tx_len   <= exp_len;
      tx_last  <= rel_last;
      tx_empty <= 1'b0;
    end else if (empty_load) begin
      tx_len   <= 7'd0;
      tx_last  <= 1'b1;
      tx_empty <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_last_read_ends_release: assert property (@(posedge clk) disable iff (rst)
    st_ctl.rd_en && rel_last |=> phase == PH_HUNT)
    else $error("release did not end after last read");

  a_no_write_during_read: assert property (@(posedge clk) disable iff (rst)
    st_ctl.wr_en |-> !st_ctl.rd_en)
    else $error("store written while releasing");

  a_write_within_frame: assert property (@(posedge clk) disable iff (rst)
    st_ctl.wr_en && rx_valid |-> cnt < exp_len)
    else $error("payload write beyond frame length");

  a_empty_result_shape: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_empty |-> tx_last && tx_len == 7'd0)
    else $error("empty-frame result malformed");
`endif

endmodule

/* design/sync_length_checksum_deframer_unit.sv */
// An empty-frame result is registered, valid the cycle after its checksum is
// taken; a first payload byte follows once release starts and the store read
// register loads. Throughput: one byte per cycle when not held off; after a
// good checksum the payload leaves at one byte per cycle unless the output
// stalls; input waits until it has left; a checksum waits on a pending result.
// Reset: sync; clears phase, counters, sum, config, tx_valid; not the store.
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_unit
// Top level: frame parser plus payload store.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_unit #(
  parameter int unsigned MAX_PAYLOAD = slcd_pkg::MaxPayloadDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [slcd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [slcd_pkg::CfgDataW-1:0] cfg_data,
  slcd_rx_if.sink                       rx,
  slcd_tx_if.source                     tx
);
  import slcd_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  store_ctl_t    st_ctl;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    wr_data;
  logic [7:0]    rd_data;
  logic          tx_empty;

  slcd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_valid  (rx.valid),
    .rx_byte   (rx.rx_byte),
    .rx_ready  (rx.ready),
    .tx_ready  (tx.ready),
    .tx_valid  (tx.valid),
    .tx_len    (tx.frame_length),
    .tx_last   (tx.last_of_frame),
    .tx_empty  (tx_empty),
    .st_ctl    (st_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr)
  );

  slcd_store #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_store (
    .clk     (clk),
    .st_ctl  (st_ctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Empty frames carry a zero payload byte
  assign tx.empty_frame  = tx_empty;
  assign tx.payload_byte = tx_empty ? 8'd0 : rd_data;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives received bytes into the sync/length/checksum deframer and checks
// every released payload byte against a cycle-free behavioral predictor.
// Covers directed frames, register extremes and random frame traffic, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import slcd_pkg::*;

  localparam int unsigned STORE_DEPTH = MaxPayloadDefault;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [6:0] frame_length;
    logic       last_of_frame;
    logic       empty_frame;
  } frame_result_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  slcd_rx_if rx_ch ();
  slcd_tx_if tx_ch ();

  sync_length_checksum_deframer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx_ch),
    .tx        (tx_ch)
  );

  // Predictor state and register copies
  phase_t        parse_phase;
  logic [7:0]    frame_store [STORE_DEPTH];
  logic [6:0]    frame_len;
  logic [6:0]    byte_count;
  logic [7:0]    frame_sum;
  logic [7:0]    sync_reg;
  logic [6:0]    limit_reg;

  frame_result_t verified_payload_q[$];
  frame_result_t want_result;
  logic [7:0]    body_bytes[$];

  int  error_count;
  int  cycle_count;
  bit  no_idle;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[sync_length_checksum_deframer_unit] ERROR");
      $finish;
    end
  end

  function automatic int unsigned effective_limit();
    return (limit_reg < STORE_DEPTH) ? limit_reg : STORE_DEPTH;
  endfunction

  // Advance the predictor by one accepted byte; queue any released results
  function automatic void predict_deframe(input logic [7:0] b);
    frame_result_t res;
    case (parse_phase)
      PH_HUNT: begin
        if (b == sync_reg) begin
          frame_sum   = b;
          parse_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b > effective_limit()) begin
          parse_phase = PH_HUNT;
        end else begin
          frame_len   = b[6:0];
          byte_count  = '0;
          frame_sum   = frame_sum + b;
          parse_phase = (b == 8'd0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        if (byte_count < STORE_DEPTH) frame_store[byte_count] = b;
        frame_sum  = frame_sum + b;
        byte_count = byte_count + 7'd1;
        if (byte_count >= frame_len) parse_phase = PH_SUM;
      end
      PH_SUM: begin
        if (b == frame_sum) begin
          if (frame_len == 7'd0) begin
            res = '{payload_byte: 8'd0, frame_length: 7'd0,
                    last_of_frame: 1'b1, empty_frame: 1'b1};
            verified_payload_q.push_back(res);
          end else begin
            for (int k = 0; k < frame_len; k++) begin
              res = '{payload_byte: frame_store[k], frame_length: frame_len,
                      last_of_frame: (k + 1 == frame_len), empty_frame: 1'b0};
              verified_payload_q.push_back(res);
            end
          end
        end
        parse_phase = PH_HUNT;
      end
      default: parse_phase = PH_HUNT;
    endcase
  endfunction

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Result sink: random back-pressure and compare each transfer in order
  always @(posedge clk) begin
    tx_ch.ready <= no_idle || ($urandom_range(99) >= 7);
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      if (verified_payload_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte 0x%0h",
                 $time, tx_ch.payload_byte);
        error_count++;
      end else begin
        want_result = verified_payload_q.pop_front();
        check_field("payload_byte", want_result.payload_byte, tx_ch.payload_byte);
        check_field("frame_length", want_result.frame_length, tx_ch.frame_length);
        check_field("last_of_frame", want_result.last_of_frame, tx_ch.last_of_frame);
        check_field("empty_frame", want_result.empty_frame, tx_ch.empty_frame);
      end
    end
  end

  // Send one byte; hold valid until the transfer completes
  task automatic send_byte(input logic [7:0] b);
    if (!no_idle && $urandom_range(99) < 7) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    predict_deframe(b);
  endtask

  // Send sync, length, body_bytes and a good or corrupted checksum
  task automatic send_frame(input bit bad_sum);
    logic [7:0] sum;
    sum = sync_reg + 8'(body_bytes.size());
    send_byte(sync_reg);
    send_byte(8'(body_bytes.size()));
    foreach (body_bytes[i]) begin
      sum = sum + body_bytes[i];
      send_byte(body_bytes[i]);
    end
    if (bad_sum) sum = sum + 8'($urandom_range(255, 1));
    send_byte(sum);
  endtask

  task automatic fill_body(input int len);
    body_bytes.delete();
    repeat (len) body_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Wait until every expected result has arrived, then let the block settle
  task automatic wait_drain();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (verified_payload_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SYNC) sync_reg = value;
    else limit_reg = value[6:0];
    @(posedge clk);
  endtask

  // Reset-value registers: empty, extreme bytes, bad sums, oversize length
  task automatic test_basic_frames();
    body_bytes.delete();
    send_frame(1'b0);
    body_bytes = '{8'h00, 8'hFF};
    send_frame(1'b0);
    body_bytes = '{8'h7F};
    send_frame(1'b1);
    // length one above the limit drops the frame
    send_byte(sync_reg);
    send_byte(8'(effective_limit() + 1));
    // zero length with a bad checksum
    body_bytes.delete();
    send_frame(1'b1);
    send_byte(8'h00);
    send_byte(8'hFF);
    body_bytes = '{8'h80, 8'h01, 8'hAA};
    send_frame(1'b0);
    wait_drain();
  endtask

  // Register extremes: zero limit, limit beyond the store, dropped length byte
  task automatic test_register_extremes();
    write_register(CFG_SYNC, 8'h00);
    write_register(CFG_LIMIT, 8'h00);
    body_bytes.delete();
    send_frame(1'b0);
    send_byte(8'h00);
    send_byte(8'h01);
    send_frame(1'b0);
    wait_drain();

    write_register(CFG_SYNC, 8'hFF);
    write_register(CFG_LIMIT, 8'h7F);
    // limit is clamped to the store depth
    send_byte(8'hFF);
    send_byte(8'(STORE_DEPTH + 1));
    fill_body(STORE_DEPTH);
    send_frame(1'b0);
    wait_drain();

    write_register(CFG_SYNC, 8'h11);
    write_register(CFG_LIMIT, 8'd16);
    // a dropped length equal to sync must not restart a frame
    send_byte(8'h11);
    send_byte(8'h11);
    send_byte(8'h00);
    body_bytes.delete();
    send_frame(1'b0);
    fill_body(16);
    send_frame(1'b0);
    wait_drain();
  endtask

  // Random frames: mostly good, some corrupted, oversized or noise
  task automatic run_random_segment(input logic [7:0] sync, input logic [7:0] limit,
                                    input int n_items, input bit quiet);
    int fed;
    int pick;
    int eff;
    int len;
    logic [7:0] noise;
    fed = 0;
    no_idle = quiet;
    write_register(CFG_SYNC, sync);
    write_register(CFG_LIMIT, limit);
    eff = effective_limit();
    while (fed < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // noise in hunt, ignored by the block
        repeat ($urandom_range(3, 1)) begin
          noise = 8'($urandom_range(255));
          if (noise == sync_reg) noise = ~noise;
          send_byte(noise);
        end
      end else if (pick < 14) begin
        send_byte(sync_reg);
        send_byte(8'($urandom_range(255, eff + 1)));
        fed += 2;
      end else begin
        if (eff == STORE_DEPTH && pick < 18) len = eff;
        else if (pick < 35) len = $urandom_range(eff);
        else len = $urandom_range((eff < 6) ? eff : 6);
        fill_body(len);
        send_frame(pick < 24);
        fed += len + 3;
      end
    end
    wait_drain();
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_segment(8'($urandom_range(255)), 8'd64, 90, 1'b1);
    run_random_segment(8'hFF, 8'h7F, 90, 1'b0);
    run_random_segment(8'h00, 8'd5, 90, 1'b0);
    run_random_segment(SyncReset, 8'(LimitReset), 90, 1'b0);
  endtask

  // Main sequence
  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SYNC;
    cfg_data      = '0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    tx_ch.ready   = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    no_idle       = 1'b0;
    parse_phase   = PH_HUNT;
    frame_len     = '0;
    byte_count    = '0;
    frame_sum     = '0;
    sync_reg      = SyncReset;
    limit_reg     = LimitReset;
    foreach (frame_store[i]) frame_store[i] = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_frames();
    test_register_extremes();
    test_random_traffic();

    if (error_count == 0) begin
      $display("[sync_length_checksum_deframer_unit] OK");
    end else begin
      $display("[sync_length_checksum_deframer_unit] ERROR");
    end
    $finish;
  end

endmodule
